[rtl/grid_square_reveal_bitmap_macros.svh]
// ----------------------------------------------------------------------------
// grid_square_reveal_bitmap_macros
// assertion macros for the checker file of the bitmap block
// ----------------------------------------------------------------------------
`ifndef GRID_SQUARE_REVEAL_BITMAP_MACROS_SVH
`define GRID_SQUARE_REVEAL_BITMAP_MACROS_SVH

// same-cycle implication, disabled during reset
`define GSRB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define GSRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/gsrb_pkg.sv]
// ----------------------------------------------------------------------------
// gsrb_pkg
// shared constants, state and interface types of the reveal bitmap block
// ----------------------------------------------------------------------------
package gsrb_pkg;

   // map geometry
   localparam int CELL_SIZE   = 16;
   localparam int MAX_CELLS_X = 256;
   localparam int MAX_CELLS_Y = 256;
   localparam int MAX_RADIUS  = 15;

   // field widths
   localparam int WORLD_WIDTH  = 16;
   localparam int RADIUS_WIDTH = 4;
   localparam int DIM_WIDTH    = 9;
   localparam int COUNT_WIDTH  = 17;
   localparam int COUNT_MAX    = (1 << COUNT_WIDTH) - 1;
   localparam int DIM_RESET    = 256;

   // bitmap storage
   localparam int BYTE_WIDTH      = 8;
   localparam int BIT_SEL_WIDTH   = $clog2(BYTE_WIDTH);
   localparam int BITMAP_BYTES    = (MAX_CELLS_X * MAX_CELLS_Y + BYTE_WIDTH - 1) / BYTE_WIDTH;
   localparam int BYTE_ADDR_WIDTH = $clog2(BITMAP_BYTES);
   localparam int POS_WIDTH       = $clog2(MAX_CELLS_X * MAX_CELLS_Y);

   // sweep arithmetic
   localparam int CELL_COORD_WIDTH = WORLD_WIDTH + 1;
   localparam int OFFSET_WIDTH     = $clog2(MAX_RADIUS + 1) + 1;
   localparam int ROW_BASE_WIDTH   = CELL_COORD_WIDTH + DIM_WIDTH + 1;

   // configuration register map
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GRID_CELLS_X = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GRID_CELLS_Y = CSR_INDEX_WIDTH'(1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_SWEEP,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_start;
      logic clear_step;
      logic accept;
      logic setup;
      logic issue;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic sweep_last;
   } ctrl_status_type;

endpackage

[rtl/gsrb_ctrl.sv]
// ----------------------------------------------------------------------------
// gsrb_ctrl
// sequencer for clearing pass, square sweep and result hand-off
// ----------------------------------------------------------------------------
module gsrb_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [gsrb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  gsrb_pkg::ctrl_status_type            status,
   output gsrb_pkg::ctrl_cmd_type               cmd
);

   gsrb_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                cfg_hit;

   // a write to a known register starts a new map
   assign cfg_hit = csr_valid && ((csr_index == gsrb_pkg::CSR_GRID_CELLS_X) ||
                                  (csr_index == gsrb_pkg::CSR_GRID_CELLS_Y));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gsrb_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      if (cfg_hit) begin
         cmd.clear_start = 1'b1;
         state_in        = gsrb_pkg::ST_CLEAR;
      end else begin
         unique case (state_ff)
            gsrb_pkg::ST_CLEAR: begin
               cmd.clear_step = 1'b1;
               if (status.clear_last) begin
                  state_in = gsrb_pkg::ST_IDLE;
               end
            end
            gsrb_pkg::ST_IDLE: begin
               if (req_valid) begin
                  cmd.accept = 1'b1;
                  state_in   = gsrb_pkg::ST_SETUP;
               end
            end
            gsrb_pkg::ST_SETUP: begin
               cmd.setup = 1'b1;
               state_in  = gsrb_pkg::ST_SWEEP;
            end
            gsrb_pkg::ST_SWEEP: begin
               cmd.issue = 1'b1;
               if (status.sweep_last) begin
                  state_in = gsrb_pkg::ST_DRAIN;
               end
            end
            gsrb_pkg::ST_DRAIN: begin
               state_in = gsrb_pkg::ST_DONE;
            end
            gsrb_pkg::ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = gsrb_pkg::ST_IDLE;
               end
            end
            default: begin
               state_in = gsrb_pkg::ST_CLEAR;
            end
         endcase
      end
   end

   always_comb begin
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_stall = (state_ff != gsrb_pkg::ST_IDLE) || cfg_hit;
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/gsrb_datapath.sv]
// ----------------------------------------------------------------------------
// gsrb_datapath
// grid registers, sweep counters, bitmap memory with read-modify-write
// ----------------------------------------------------------------------------
module gsrb_datapath (
   input  logic                                         clock,
   input  logic                                         reset,
   input  gsrb_pkg::ctrl_cmd_type                       cmd,
   output gsrb_pkg::ctrl_status_type                    status,
   input  logic                                         csr_valid,
   input  logic [gsrb_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input  logic [gsrb_pkg::DIM_WIDTH-1:0]               csr_data,
   input  logic signed [gsrb_pkg::WORLD_WIDTH-1:0]      req_world_x,
   input  logic signed [gsrb_pkg::WORLD_WIDTH-1:0]      req_world_y,
   input  logic [gsrb_pkg::RADIUS_WIDTH-1:0]            req_reveal_radius,
   output logic                                         rsp_any_changed,
   output logic [gsrb_pkg::COUNT_WIDTH-1:0]             rsp_open_cells
);

   localparam int CW = gsrb_pkg::CELL_COORD_WIDTH;
   localparam int OW = gsrb_pkg::OFFSET_WIDTH;
   localparam int RW = gsrb_pkg::ROW_BASE_WIDTH;
   localparam int AW = gsrb_pkg::BYTE_ADDR_WIDTH;
   localparam int BW = gsrb_pkg::BYTE_WIDTH;
   localparam int SW = gsrb_pkg::BIT_SEL_WIDTH;
   localparam int DW = gsrb_pkg::DIM_WIDTH;
   localparam int NW = gsrb_pkg::COUNT_WIDTH;

   // grid size registers
   logic [DW-1:0] grid_x_ff, grid_y_ff;
   logic [DW-1:0] nxmax, nymax;

   // item registers
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [OW-1:0] rad_ff, rad_in;
   int                   cx_full, cy_full;

   // sweep position
   logic signed [OW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [RW-1:0] row_base_ff, row_base_in;
   logic signed [CW-1:0] nx, ny, ny0;
   logic signed [RW-1:0] pos_full;
   logic [gsrb_pkg::POS_WIDTH-1:0] pos;
   logic                 in_grid;

   // read-modify-write stage
   logic          p1_valid_ff, p1_valid_in;
   logic [AW-1:0] p1_addr_ff, p1_addr_in;
   logic [SW-1:0] p1_bit_ff, p1_bit_in;
   logic [BW-1:0] rd_data_ff;
   logic          last_wr_valid_ff;
   logic [AW-1:0] last_wr_addr_ff;
   logic [BW-1:0] last_wr_data_ff;
   logic [BW-1:0] cur_byte, bit_mask, merged;
   logic          new_bit;

   // memory port
   logic [BW-1:0] cell_bitmap_mem [gsrb_pkg::BITMAP_BYTES];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [BW-1:0] mem_wdata;

   // clear sweep, counters, result
   logic [AW-1:0] clear_addr_ff, clear_addr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          changed_ff, changed_in;
   logic          rsp_any_changed_ff;
   logic [NW-1:0] rsp_open_cells_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_x_ff <= DW'(gsrb_pkg::DIM_RESET);
         grid_y_ff <= DW'(gsrb_pkg::DIM_RESET);
      end else if (csr_valid) begin
         if (csr_index == gsrb_pkg::CSR_GRID_CELLS_X) begin
            grid_x_ff <= csr_data;
         end
         if (csr_index == gsrb_pkg::CSR_GRID_CELLS_Y) begin
            grid_y_ff <= csr_data;
         end
      end
   end

   assign nxmax = (32'(grid_x_ff) > gsrb_pkg::MAX_CELLS_X) ? DW'(gsrb_pkg::MAX_CELLS_X)
                                                          : grid_x_ff;
   assign nymax = (32'(grid_y_ff) > gsrb_pkg::MAX_CELLS_Y) ? DW'(gsrb_pkg::MAX_CELLS_Y)
                                                          : grid_y_ff;

   // centre cell, truncation toward zero
   always_comb begin
      cx_full = int'(req_world_x) / gsrb_pkg::CELL_SIZE;
      cy_full = int'(req_world_y) / gsrb_pkg::CELL_SIZE;
      cx_in   = CW'(cx_full);
      cy_in   = CW'(cy_full);
      rad_in  = (32'(req_reveal_radius) > gsrb_pkg::MAX_RADIUS) ? OW'(gsrb_pkg::MAX_RADIUS)
                                                                : OW'(req_reveal_radius);
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         rad_ff <= rad_in;
      end
   end

   // sweep over the square, row by row
   assign ny0 = cy_ff - CW'(rad_ff);
   assign nx  = cx_ff + CW'(dx_ff);
   assign ny  = cy_ff + CW'(dy_ff);

   assign in_grid = !nx[CW-1] && !ny[CW-1] &&
                    (nx[CW-2:0] < (CW-1)'(nxmax)) && (ny[CW-2:0] < (CW-1)'(nymax));

   assign pos_full = row_base_ff + RW'(nx);
   assign pos      = pos_full[gsrb_pkg::POS_WIDTH-1:0];

   assign status.sweep_last = (dx_ff == rad_ff) && (dy_ff == rad_ff);

   always_comb begin
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      row_base_in = row_base_ff;
      if (cmd.setup) begin
         dx_in       = -rad_ff;
         dy_in       = -rad_ff;
         row_base_in = RW'(ny0) * $signed(RW'(nxmax));
      end else if (cmd.issue) begin
         if (dx_ff == rad_ff) begin
            dx_in       = -rad_ff;
            dy_in       = OW'(dy_ff + 1);
            row_base_in = row_base_ff + $signed(RW'(nxmax));
         end else begin
            dx_in = OW'(dx_ff + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      row_base_ff <= row_base_in;
   end

   // cell issue into the read-modify-write stage
   assign p1_valid_in = cmd.issue && in_grid;
   assign p1_addr_in  = AW'(pos >> SW);
   assign p1_bit_in   = pos[SW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff      <= 1'b0;
         last_wr_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff      <= p1_valid_in;
         last_wr_valid_ff <= p1_valid_ff;
      end
      p1_addr_ff      <= p1_addr_in;
      p1_bit_ff       <= p1_bit_in;
      last_wr_addr_ff <= p1_addr_ff;
      last_wr_data_ff <= merged;
   end

   // forward the byte written last cycle, the memory read missed it
   assign cur_byte = (last_wr_valid_ff && (last_wr_addr_ff == p1_addr_ff)) ? last_wr_data_ff
                                                                          : rd_data_ff;
   assign bit_mask = BW'(1) << p1_bit_ff;
   assign merged   = cur_byte | bit_mask;
   assign new_bit  = p1_valid_ff && ((cur_byte & bit_mask) == '0);

   // bitmap memory
   assign mem_we    = cmd.clear_step || p1_valid_ff;
   assign mem_waddr = cmd.clear_step ? clear_addr_ff : p1_addr_ff;
   assign mem_wdata = cmd.clear_step ? '0 : merged;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_bitmap_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= cell_bitmap_mem[p1_addr_in];
   end

   // clearing pass
   always_comb begin
      priority if (cmd.clear_start) begin
         clear_addr_in = '0;
      end else if (cmd.clear_step) begin
         clear_addr_in = AW'(clear_addr_ff + 1'b1);
      end else begin
         clear_addr_in = clear_addr_ff;
      end
   end

   assign status.clear_last = (clear_addr_ff == AW'(gsrb_pkg::BITMAP_BYTES - 1));

   // running count and change flag
   always_comb begin
      priority if (cmd.clear_start) begin
         count_in = '0;
      end else if (new_bit && (32'(count_ff) < gsrb_pkg::COUNT_MAX)) begin
         count_in = NW'(count_ff + 1'b1);
      end else begin
         count_in = count_ff;
      end
      priority if (cmd.accept) begin
         changed_in = 1'b0;
      end else if (new_bit) begin
         changed_in = 1'b1;
      end else begin
         changed_in = changed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
         count_ff      <= '0;
         changed_ff    <= 1'b0;
      end else begin
         clear_addr_ff <= clear_addr_in;
         count_ff      <= count_in;
         changed_ff    <= changed_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_any_changed_ff <= changed_ff;
         rsp_open_cells_ff  <= count_ff;
      end
   end

   assign rsp_any_changed = rsp_any_changed_ff;
   assign rsp_open_cells  = rsp_open_cells_ff;

endmodule

[rtl/grid_square_reveal_bitmap.sv]
// requests are taken one at a time: a new request is accepted only after the
// result of the last one is loaded; the sweep covers the square of side 2r+1,
// r the clamped radius, through the bitmap memory port, one cell read-modify-write per cycle
// reset, and any write to a grid register, runs a clearing pass over every byte
// of the bitmap; requests stall during it, register writes are always taken
// ----------------------------------------------------------------------------
// grid_square_reveal_bitmap
// visited-cell bitmap of one grid map with square reveal and running count
// ----------------------------------------------------------------------------
module grid_square_reveal_bitmap (
   input  logic                                         clock,
   input  logic                                         reset,
   // configuration writes
   input  logic                                         csr_valid,
   output logic                                         csr_ready,
   input  logic [gsrb_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input  logic [gsrb_pkg::DIM_WIDTH-1:0]               csr_data,
   // request channel
   input  logic                                         req_valid,
   output logic                                         req_stall,
   input  logic signed [gsrb_pkg::WORLD_WIDTH-1:0]      req_world_x,
   input  logic signed [gsrb_pkg::WORLD_WIDTH-1:0]      req_world_y,
   input  logic [gsrb_pkg::RADIUS_WIDTH-1:0]            req_reveal_radius,
   // response channel
   output logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   output logic                                         rsp_any_changed,
   output logic [gsrb_pkg::COUNT_WIDTH-1:0]             rsp_open_cells
);

   // controller and datapath talk through these two groups only
   gsrb_pkg::ctrl_cmd_type    cmd;
   gsrb_pkg::ctrl_status_type status;

   // register writes never wait; the map is rebuilt behind them
   assign csr_ready = 1'b1;

   // sequencer: clearing pass, square sweep, result hand-off
   gsrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // bitmap memory, sweep counters, count and result register
   gsrb_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_world_x       (req_world_x),
      .req_world_y       (req_world_y),
      .req_reveal_radius (req_reveal_radius),
      .rsp_any_changed   (rsp_any_changed),
      .rsp_open_cells    (rsp_open_cells)
   );

endmodule

[rtl/gsrb_checker.sv]
// ----------------------------------------------------------------------------
// gsrb_checker
// port-level checks of the reveal bitmap block, bound to the top level
// ----------------------------------------------------------------------------
`include "grid_square_reveal_bitmap_macros.svh"

module gsrb_checker (
   input logic                                         clock,
   input logic                                         reset,
   input logic                                         csr_valid,
   input logic                                         csr_ready,
   input logic [gsrb_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input logic                                         req_stall,
   input logic                                         rsp_valid,
   input logic                                         rsp_stall,
   input logic                                         rsp_any_changed,
   input logic [gsrb_pkg::COUNT_WIDTH-1:0]             rsp_open_cells
);

   logic rsp_held;
   logic grid_write;

   assign rsp_held   = rsp_valid && rsp_stall;
   assign grid_write = csr_valid && csr_ready &&
                       ((csr_index == gsrb_pkg::CSR_GRID_CELLS_X) ||
                        (csr_index == gsrb_pkg::CSR_GRID_CELLS_Y));

   // a stalled result beat stays
   `GSRB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid, "rsp beat dropped")

   // and its payload holds
   `GSRB_ASSERT_NEXT(a_rsp_cnt, clock, reset, rsp_held, $stable(rsp_open_cells), "rsp count moved")
   `GSRB_ASSERT_NEXT(a_rsp_flag, clock, reset, rsp_held, $stable(rsp_any_changed), "rsp flag moved")

   // the clearing pass follows reset
   `GSRB_ASSERT_SAME(a_reset_clear, clock, reset, $past(reset), req_stall, "request during clear")

   // a grid register write starts a new map, requests wait
   `GSRB_ASSERT_NEXT(a_cfg_clear, clock, reset, grid_write, req_stall, "request after grid write")

endmodule

bind grid_square_reveal_bitmap gsrb_checker u_gsrb_checker (.*);
